>>> design/multi_queue_shared_buffer_defines.svh
// Assertion macros for the multi-queue shared buffer.
// Used by the port checker; depends on nothing else.
`ifndef MULTI_QUEUE_SHARED_BUFFER_DEFINES_SVH
`define MULTI_QUEUE_SHARED_BUFFER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent
`define MQSB_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define MQSB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Consequent must hold later than the antecedent, not in the same cycle
`define MQSB_ASSERT_LATER(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##2 (cons)) \
      else $error(msg);

`endif

>>> design/mqsb_pkg.sv
// Shared types and codes for the multi-queue shared buffer.
// No dependencies; imported by the top level and the port checker.
`timescale 1ns / 1ps

package mqsb_pkg;

   // Fixed request and response field widths
   localparam int QUEUE_ID_WIDTH = 4;
   localparam int QUEUE_ID_RANGE = 2 ** QUEUE_ID_WIDTH;
   localparam int VALUE_WIDTH    = 32;
   localparam int STATUS_WIDTH   = 2;

   // Operation codes
   localparam logic OP_ENQUEUE = 1'b0;
   localparam logic OP_DEQUEUE = 1'b1;

   // Response status codes
   localparam logic [STATUS_WIDTH-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_WIDTH-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_WIDTH-1:0] ST_EMPTY = 2'd2;

   typedef struct packed {
      logic                      operation;
      logic [QUEUE_ID_WIDTH-1:0] queue_id;
      logic [VALUE_WIDTH-1:0]    value;
   } mqsb_req_type;

   typedef struct packed {
      logic [STATUS_WIDTH-1:0] status;
      logic [VALUE_WIDTH-1:0]  data_out;
   } mqsb_rsp_type;

endpackage

>>> design/multi_queue_shared_buffer.sv
// Several FIFO queues held as linked lists in one shared data store.
// Depends on mqsb_pkg for the request and response types and codes.
`timescale 1ns / 1ps

// Each request has an accept cycle and an update cycle. In the accept cycle
// the link and data memories are read (and an enqueue writes its data and
// tail link); in the following cycle the synchronous read data comes back,
// the free list or queue head is updated and the response is registered.
// A new request is taken only after the update cycle and while no stalled
// response waits. The link memory needs no clearing pass after reset: slots
// at or above a fill mark are taken to hold their initial chain value, so
// requests are taken from the first cycle after reset. Queue numbers at or
// above NUM_QUEUES are rejected without state change.
module multi_queue_shared_buffer #(
   parameter int NUM_QUEUES  = 16,
   parameter int STORE_DEPTH = 256,
   parameter int DATA_WIDTH  = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  mqsb_pkg::mqsb_req_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output mqsb_pkg::mqsb_rsp_type rsp_data
);
   import mqsb_pkg::*;

   // Only queue numbers that fit the queue_id field can ever be addressed
   localparam int QN  = (NUM_QUEUES < QUEUE_ID_RANGE) ? NUM_QUEUES : QUEUE_ID_RANGE;
   localparam int QIW = (QN > 1) ? $clog2(QN) : 1;
   localparam int SW  = $clog2(STORE_DEPTH);
   localparam int LW  = $clog2(STORE_DEPTH + 1);
   localparam logic [LW-1:0] SLOT_NULL = LW'(STORE_DEPTH);

   localparam logic PHASE_IDLE   = 1'b0;
   localparam logic PHASE_UPDATE = 1'b1;

   // Memories
   logic [LW-1:0]         link_mem [STORE_DEPTH];
   logic [DATA_WIDTH-1:0] data_mem [STORE_DEPTH];

   // Control state
   logic          phase_ff, phase_in;
   logic [LW-1:0] free_head_ff, free_head_in;
   logic [LW-1:0] fill_ff, fill_in;
   logic [LW-1:0] queue_head_ff [QN];
   logic [SW-1:0] queue_tail_ff [QN];
   logic          rsp_valid_ff, rsp_valid_in;

   // Request held between the two phases
   logic                    deq_ff;
   logic [QIW-1:0]          qidx_ff;
   logic                    ok_ff;
   logic                    fresh_ff;
   logic                    last_ff;
   logic [SW-1:0]           slot_ff;
   logic [STATUS_WIDTH-1:0] status_ff;
   logic [LW-1:0]           link_rd_ff;
   logic [DATA_WIDTH-1:0]   data_rd_ff;
   mqsb_rsp_type            rsp_ff;

   // Accept-cycle decode
   logic                       accept;
   logic                       q_in_range;
   logic [QIW-1:0]             q_idx;
   logic [LW-1:0]              head_q;
   logic [SW-1:0]              tail_q;
   logic [SW-1:0]              head_slot;
   logic [SW-1:0]              free_slot;
   logic                       is_deq;
   logic                       head_null;
   logic                       free_null;
   logic                       enq_ok;
   logic                       deq_ok;
   logic                       fresh;
   logic [DATA_WIDTH+VALUE_WIDTH-1:0] value_ext;
   logic [DATA_WIDTH+VALUE_WIDTH-1:0] rd_ext;
   logic [STATUS_WIDTH-1:0]    status_in;

   // Link memory write port
   logic          link_wr_en;
   logic [SW-1:0] link_wr_addr;
   logic [LW-1:0] link_wr_data;
   logic          update_deq;

   // One request in flight; accept only when the response register drains
   assign req_stall = (phase_ff == PHASE_UPDATE) | (rsp_valid_ff & rsp_stall);
   assign accept    = req_valid & ~req_stall;

   assign q_in_range = 32'(req_data.queue_id) < NUM_QUEUES;
   assign q_idx      = q_in_range ? req_data.queue_id[QIW-1:0] : '0;
   assign head_q     = queue_head_ff[q_idx];
   assign tail_q     = queue_tail_ff[q_idx];
   assign head_slot  = head_q[SW-1:0];
   assign free_slot  = free_head_ff[SW-1:0];
   assign is_deq     = req_data.operation == OP_DEQUEUE;
   assign head_null  = head_q == SLOT_NULL;
   assign free_null  = free_head_ff == SLOT_NULL;
   assign enq_ok     = ~is_deq & q_in_range & ~free_null;
   assign deq_ok     = is_deq & q_in_range & ~head_null;
   // Free slot never linked yet: its link is taken to be the initial chain value
   assign fresh      = free_head_ff >= fill_ff;
   assign value_ext  = {{DATA_WIDTH{1'b0}}, req_data.value};

   always_comb begin
      if (is_deq) begin
         status_in = deq_ok ? ST_OK : ST_EMPTY;
      end else begin
         status_in = enq_ok ? ST_OK : ST_FULL;
      end
   end

   // Enqueue links the old tail in the accept cycle; dequeue pushes the
   // freed slot onto the free list in the update cycle
   assign update_deq = (phase_ff == PHASE_UPDATE) & ok_ff & deq_ff;

   always_comb begin
      link_wr_en   = 1'b0;
      link_wr_addr = tail_q;
      link_wr_data = free_head_ff;
      if (update_deq) begin
         link_wr_en   = 1'b1;
         link_wr_addr = slot_ff;
      end else if (accept & enq_ok & ~head_null) begin
         link_wr_en   = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (link_wr_en) begin
         link_mem[link_wr_addr] <= link_wr_data;
      end
      if (accept & (enq_ok | deq_ok)) begin
         link_rd_ff <= link_mem[is_deq ? head_slot : free_slot];
      end
   end

   always_ff @(posedge clock) begin
      if (accept & enq_ok) begin
         data_mem[free_slot] <= value_ext[DATA_WIDTH-1:0];
      end
      if (accept & deq_ok) begin
         data_rd_ff <= data_mem[head_slot];
      end
   end

   // Next values of the control registers
   always_comb begin
      phase_in     = phase_ff;
      free_head_in = free_head_ff;
      fill_in      = fill_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff & ~rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (accept) begin
         phase_in = PHASE_UPDATE;
         if (enq_ok & fresh) begin
            fill_in = free_head_ff + LW'(1);
         end
      end
      if (phase_ff == PHASE_UPDATE) begin
         phase_in     = PHASE_IDLE;
         rsp_valid_in = 1'b1;
         if (ok_ff) begin
            if (deq_ff) begin
               free_head_in = LW'(slot_ff);
            end else if (fresh_ff) begin
               free_head_in = LW'(slot_ff) + LW'(1);
            end else begin
               free_head_in = link_rd_ff;
            end
         end
      end
   end

   // Control registers and queue heads
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PHASE_IDLE;
         free_head_ff <= '0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < QN; i++) begin
            queue_head_ff[i] <= SLOT_NULL;
         end
      end else begin
         phase_ff     <= phase_in;
         free_head_ff <= free_head_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
         if (accept & enq_ok & head_null) begin
            queue_head_ff[q_idx] <= free_head_ff;
         end
         if (update_deq) begin
            queue_head_ff[qidx_ff] <= last_ff ? SLOT_NULL : link_rd_ff;
         end
      end
   end

   // Tails and the request held over to the update cycle
   always_ff @(posedge clock) begin
      if (accept) begin
         deq_ff    <= is_deq;
         qidx_ff   <= q_idx;
         ok_ff     <= enq_ok | deq_ok;
         fresh_ff  <= fresh;
         last_ff   <= head_slot == tail_q;
         slot_ff   <= is_deq ? head_slot : free_slot;
         status_ff <= status_in;
         if (enq_ok) begin
            queue_tail_ff[q_idx] <= free_slot;
         end
      end
   end

   // Response register
   assign rd_ext = {{VALUE_WIDTH{1'b0}}, data_rd_ff};

   always_ff @(posedge clock) begin
      if (phase_ff == PHASE_UPDATE) begin
         rsp_ff.status   <= status_ff;
         rsp_ff.data_out <= (ok_ff & deq_ff) ? rd_ext[VALUE_WIDTH-1:0] : '0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

>>> design/mqsb_checker.sv
// Port-level checker for the multi-queue shared buffer, bound to the top level.
// Depends on mqsb_pkg and the assertion macros in the defines header.
`timescale 1ns / 1ps
`include "multi_queue_shared_buffer_defines.svh"

module mqsb_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_stall,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input mqsb_pkg::mqsb_rsp_type rsp_data
);
   import mqsb_pkg::*;

   // One request in flight: the next is held off in the cycle after an accept
   `MQSB_ASSERT_NEXT(a_busy_after_accept, clock, reset,
      req_valid && !req_stall, req_stall, "request accepted while busy")

   // Every accepted request has its response valid after the update cycle
   `MQSB_ASSERT_LATER(a_rsp_latency, clock, reset,
      req_valid && !req_stall, rsp_valid, "response missing after request")

   // Rejected operations return no data
   `MQSB_ASSERT_SAME(a_reject_zero, clock, reset,
      rsp_valid && (rsp_data.status != ST_OK), rsp_data.data_out == '0,
      "data on rejected request")

   // A stalled response holds
   `MQSB_ASSERT_NEXT(a_rsp_hold, clock, reset,
      rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data),
      "stalled response changed")

endmodule

bind multi_queue_shared_buffer mqsb_checker u_mqsb_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

>>> tb/tb_multi_queue_shared_buffer.sv
// Self-checking testbench for the multi-queue shared buffer.
// Uses mqsb_pkg for the request/response types and codes; drives the top level only.
`timescale 1ns / 1ps

module tb_multi_queue_shared_buffer;
   import mqsb_pkg::*;

   localparam int NUM_QUEUES  = 16;
   localparam int STORE_DEPTH = 256;
   localparam int DATA_WIDTH  = 32;
   localparam int SLOT_NULL   = STORE_DEPTH;
   localparam int CYCLE_LIMIT = 200000;
   localparam int QUIET_TAIL  = 100;
   localparam int LONG_HOLD   = 80;
   localparam int HOLD_AFTER  = 300;
   localparam int DRAIN_WAIT  = 20;

   typedef logic [8:0] slot_type;

   typedef struct {
      bit           wait_drain;
      mqsb_req_type req;
   } stim_item_type;

   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   mqsb_req_type req_data  = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   mqsb_rsp_type rsp_data;

   // Pending stimulus and the responses still owed by the block
   stim_item_type pending_reqs [$];
   mqsb_rsp_type  owed_rsps [$];

   // Shadow copy of the buffer state
   logic [DATA_WIDTH-1:0] shadow_data [STORE_DEPTH];
   slot_type              shadow_link [STORE_DEPTH];
   slot_type              shadow_head [NUM_QUEUES];
   slot_type              shadow_tail [NUM_QUEUES];
   slot_type              shadow_free;
   int                    shadow_used;

   int  errors       = 0;
   int  cycle_count  = 0;
   int  rsp_count    = 0;
   int  n_enq_ok     = 0;
   int  n_deq_ok     = 0;
   int  n_full       = 0;
   int  n_empty      = 0;
   int  peak_used    = 0;
   int  gap_left     = 0;
   int  stall_left   = 0;
   int  hold_left    = 0;
   bit  hold_done    = 1'b0;
   bit  holding      = 1'b0;
   logic quiet_phase = 1'b0;

   multi_queue_shared_buffer #(
      .NUM_QUEUES (NUM_QUEUES),
      .STORE_DEPTH(STORE_DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

   always #5 clock = ~clock;

   // Shadow state after reset: free list chains every slot, all queues empty
   function automatic void clear_shadow();
      for (int i = 0; i < STORE_DEPTH; i++) begin
         shadow_data[i] = '0;
         shadow_link[i] = slot_type'(i + 1);
      end
      shadow_link[STORE_DEPTH-1] = slot_type'(SLOT_NULL);
      for (int i = 0; i < NUM_QUEUES; i++) begin
         shadow_head[i] = slot_type'(SLOT_NULL);
         shadow_tail[i] = '0;
      end
      shadow_free = '0;
      shadow_used = 0;
   endfunction

   // Apply one request to the shadow lists and return the response it gives
   function automatic mqsb_rsp_type next_queue_rsp(mqsb_req_type r);
      mqsb_rsp_type              rsp;
      slot_type                  slot;
      int                        q;
      logic [QUEUE_ID_WIDTH-1:0] qi;
      q = int'(r.queue_id);
      qi = r.queue_id;
      rsp = '0;
      if (r.operation == OP_ENQUEUE) begin
         if (q >= NUM_QUEUES || shadow_free >= STORE_DEPTH) begin
            rsp.status = ST_FULL;
            n_full++;
         end else begin
            slot = shadow_free;
            shadow_free = shadow_link[slot[7:0]];
            if (shadow_head[qi] >= STORE_DEPTH)
               shadow_head[qi] = slot;
            else if (shadow_tail[qi] < STORE_DEPTH)
               shadow_link[shadow_tail[qi][7:0]] = slot;
            shadow_link[slot[7:0]] = slot_type'(SLOT_NULL);
            shadow_tail[qi] = slot;
            shadow_data[slot[7:0]] = r.value[DATA_WIDTH-1:0];
            rsp.status = ST_OK;
            shadow_used++;
            if (shadow_used > peak_used) peak_used = shadow_used;
            n_enq_ok++;
         end
      end else begin
         if (q >= NUM_QUEUES || shadow_head[qi] >= STORE_DEPTH) begin
            rsp.status = ST_EMPTY;
            n_empty++;
         end else begin
            slot = shadow_head[qi];
            shadow_head[qi] = shadow_link[slot[7:0]];
            shadow_link[slot[7:0]] = shadow_free;
            shadow_free = slot;
            rsp.data_out = VALUE_WIDTH'(shadow_data[slot[7:0]]);
            rsp.status = ST_OK;
            shadow_used--;
            n_deq_ok++;
         end
      end
      return rsp;
   endfunction

   function automatic void add_req(logic op, int q, logic [31:0] val);
      stim_item_type it;
      it.wait_drain      = 1'b0;
      it.req.operation   = op;
      it.req.queue_id    = q[QUEUE_ID_WIDTH-1:0];
      it.req.value       = val;
      pending_reqs.push_back(it);
   endfunction

   // Sender waits here until every owed response has come back
   function automatic void add_drain_point();
      stim_item_type it;
      it.wait_drain = 1'b1;
      it.req        = '0;
      pending_reqs.push_back(it);
   endfunction

   // Random requests; queue numbers lean towards a few queues so lists get long
   function automatic void add_random(int count, int enq_pct);
      logic op;
      int   q;
      for (int i = 0; i < count; i++) begin
         op = ($urandom_range(0, 99) < enq_pct) ? OP_ENQUEUE : OP_DEQUEUE;
         q  = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 3) : $urandom_range(0, 15);
         add_req(op, q, $urandom);
      end
   endfunction

   // Request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid   <= 1'b0;
         quiet_phase <= 1'b0;
         gap_left    = 0;
      end else begin
         holding = req_valid;
         if (req_valid && !req_stall) begin
            owed_rsps.push_back(next_queue_rsp(req_data));
            holding = 1'b0;
         end
         quiet_phase <= (pending_reqs.size() < QUIET_TAIL);
         if (!holding) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_reqs.size() == 0) begin
               req_valid <= 1'b0;
            end else if (pending_reqs[0].wait_drain) begin
               if (owed_rsps.size() == 0) void'(pending_reqs.pop_front());
               req_valid <= 1'b0;
            end else if (!quiet_phase && $urandom_range(0, 9) == 0) begin
               gap_left = $urandom_range(0, 3);
               req_valid <= 1'b0;
            end else begin
               req_data  <= pending_reqs.pop_front().req;
               req_valid <= 1'b1;
            end
         end
      end
   end

   // Response monitor and receiver back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            rsp_count++;
            if (owed_rsps.size() == 0) begin
               errors++;
               $display("%0t: unexpected response, expected none, actual status=%0d data=%h",
                        $time, rsp_data.status, rsp_data.data_out);
            end else if (rsp_data.status !== owed_rsps[0].status ||
                         rsp_data.data_out !== owed_rsps[0].data_out) begin
               errors++;
               $display("%0t: mismatch, expected status=%0d data=%h, actual status=%0d data=%h",
                        $time, owed_rsps[0].status, owed_rsps[0].data_out,
                        rsp_data.status, rsp_data.data_out);
               void'(owed_rsps.pop_front());
            end else begin
               void'(owed_rsps.pop_front());
            end
         end
         // long hold-off once, so the block backs up into the request side
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (!hold_done && rsp_count >= HOLD_AFTER) begin
            hold_done = 1'b1;
            hold_left = LONG_HOLD - 1;
            rsp_stall <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (!quiet_phase && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 3);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d responses owed", $time, owed_rsps.size());
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin
      clear_shadow();

      // Directed: empty queues, extreme values and queue numbers, FIFO order
      add_req(OP_DEQUEUE, 0, 32'h0000_0000);
      add_req(OP_DEQUEUE, 15, 32'hFFFF_FFFF);
      add_req(OP_ENQUEUE, 0, 32'h0000_0000);
      add_req(OP_ENQUEUE, 0, 32'hFFFF_FFFF);
      add_req(OP_ENQUEUE, 15, 32'hA5A5_A5A5);
      add_req(OP_ENQUEUE, 7, 32'h5A5A_5A5A);
      add_req(OP_DEQUEUE, 0, 32'h1234_5678);
      add_req(OP_DEQUEUE, 0, 32'h0000_0000);
      add_req(OP_DEQUEUE, 0, 32'h0000_0000);
      add_req(OP_DEQUEUE, 15, 32'h0000_0000);
      add_req(OP_DEQUEUE, 7, 32'h0000_0000);
      add_req(OP_DEQUEUE, 7, 32'h0000_0000);
      add_req(OP_ENQUEUE, 3, 32'h0000_0001);
      add_req(OP_ENQUEUE, 4, 32'h0000_0002);
      add_req(OP_ENQUEUE, 3, 32'h8000_0003);
      add_req(OP_DEQUEUE, 4, 32'h0000_0000);
      add_req(OP_DEQUEUE, 3, 32'h0000_0000);
      add_req(OP_ENQUEUE, 8, 32'h7FFF_FFFF);
      add_req(OP_DEQUEUE, 3, 32'h0000_0000);
      add_req(OP_DEQUEUE, 8, 32'h0000_0000);
      add_drain_point();

      // Fill until the store is full, pause, then drain, then a mixed tail
      add_random(350, 90);
      add_drain_point();
      add_random(350, 10);
      add_random(300, 50);

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      while (pending_reqs.size() != 0 || req_valid || owed_rsps.size() != 0)
         @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (owed_rsps.size() != 0) begin
         errors++;
         $display("%0t: %0d responses never arrived", $time, owed_rsps.size());
      end

      $display("Checked %0d responses: %0d enqueues, %0d dequeues, %0d full, %0d empty",
               rsp_count, n_enq_ok, n_deq_ok, n_full, n_empty);
      $display("Peak store occupancy %0d of %0d slots, %0d mismatches",
               peak_used, STORE_DEPTH, errors);
      if (errors == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
